FILE: design/assert_macros.svh
// Assertion macros shared by the checker modules of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A signal keeps its value in the cycle after a condition holds.
`define ASSERT_HOLD(label, clk, rst_n, cond, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
        else $error(msg);

`endif

FILE: design/ckpr_pkg.sv
// Types and codes shared by the clock page replacer modules.
package ckpr_pkg;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_REPLACE = 2'd1,
        OP_PIN     = 2'd2,
        OP_UNPIN   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_NO_VICTIM    = 3'd1,
        ST_NOT_RESIDENT = 3'd2,
        ST_FULL         = 3'd3,
        ST_NOT_FULL     = 3'd4,
        ST_UNPIN_ZERO   = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_DONE
    } t_state;

    localparam logic [15:0] PIN_MAX = 16'hFFFF;
    localparam logic [6:0]  CAPACITY_RESET = 7'd64;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] page;
        logic [5:0]  frame;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] victim_page;
        logic [5:0]  victim_frame;
    } t_out_item;

    // One slot of the buffer pool as held in memory.
    typedef struct packed {
        logic [31:0] tag;
        logic [5:0]  frame;
        logic        ref_bit;
        logic [15:0] pin;
    } t_entry;

    // Verdict of the slot evaluation unit for the current slot.
    typedef struct packed {
        logic    match;
        logic    victim;
        logic    do_write;
        t_status status;
        t_entry  entry;
    } t_eval;

endpackage

FILE: design/ckpr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ckpr_ram #(
    parameter int WIDTH = 55,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: design/ckpr_eval.sv
// Slot evaluation unit: tag compare, pin count update and clock decision for one slot.
module ckpr_eval
    import ckpr_pkg::*;
(
    input  t_op         i_op,
    input  logic [31:0] i_page,
    input  t_entry      i_entry,
    output t_eval       o_eval
);

    logic w_unpinned;

    assign w_unpinned = (i_entry.pin == '0);

    always_comb begin
        o_eval          = '0;
        o_eval.match    = (i_entry.tag == i_page);
        o_eval.status   = ST_OK;
        o_eval.entry    = i_entry;
        case (i_op)
            OP_REPLACE: begin
                // An unpinned slot either loses its reference bit or is the victim.
                o_eval.do_write = w_unpinned;
                o_eval.victim   = w_unpinned && !i_entry.ref_bit;
                if (i_entry.ref_bit) begin
                    o_eval.entry.ref_bit = 1'b0;
                end else begin
                    o_eval.entry.tag     = i_page;
                    o_eval.entry.ref_bit = 1'b1;
                end
            end
            OP_PIN: begin
                o_eval.do_write = o_eval.match;
                if (i_entry.pin != PIN_MAX) begin
                    o_eval.entry.pin = i_entry.pin + 16'd1;
                end
            end
            OP_UNPIN: begin
                o_eval.do_write = o_eval.match;
                if (w_unpinned) begin
                    o_eval.status = ST_UNPIN_ZERO;
                end else begin
                    o_eval.entry.pin = i_entry.pin - 16'd1;
                end
            end
            default: begin
                o_eval.do_write = 1'b0;
            end
        endcase
    end

endmodule

FILE: design/clock_page_replacer.sv
// Top level of the clock page replacer: sequencer, slot memory and result register.
//
//  Channel   Direction  Handshake                  Payload
//  input     in         i_in_valid / o_in_stall    i_in_item  (t_in_item)
//  output    out        o_out_valid / i_out_stall  o_out_item (t_out_item)
//  config    in         i_cfg_wr_en                i_cfg_wr_data (capacity)
//
// Insert and every early-exit case go from accept straight to the result load in S_DONE.
// Pin and unpin scan from the newest slot down, each slot through the registered
// memory read (S_READ, then S_CHECK). Replace examines slots the same way, for at
// most 2 x filled slots.
// Reset is synchronous; the slot memory is not cleared, since every slot is written by
// an insert before it is ever read. The block takes a new transaction while a
// finished result still waits under output stall.
module clock_page_replacer
    import ckpr_pkg::*;
#(
    parameter int SLOTS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_wr_en,
    input  logic [6:0] i_cfg_wr_data,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    // Slot index, fill count and a width wide enough for both the count and capacity.
    localparam int IDX_W  = $clog2(SLOTS);
    localparam int FILL_W = $clog2(SLOTS + 1);
    localparam int CW     = (FILL_W > 7) ? FILL_W : 7;
    localparam int SW     = FILL_W + 1;

    t_state            r_state, n_state;
    t_op               r_op, n_op;
    logic [31:0]       r_page, n_page;
    logic [FILL_W-1:0] r_filled, n_filled;
    logic [IDX_W-1:0]  r_hand, n_hand;
    logic [IDX_W-1:0]  r_addr, n_addr;
    logic [SW-1:0]     r_steps, n_steps;
    logic [6:0]        r_capacity, n_capacity;
    t_out_item         r_res, n_res;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    logic              w_accept;
    logic [CW-1:0]     w_eff_cap;
    logic [CW-1:0]     w_filled_ext;
    logic [IDX_W-1:0]  w_last;
    logic [IDX_W-1:0]  w_slot;
    logic [SW-1:0]     w_step_limit;
    logic              w_out_free;

    logic              w_wr_en;
    logic [IDX_W-1:0]  w_wr_addr;
    t_entry            w_wr_data;
    logic              w_rd_en;
    logic [IDX_W-1:0]  w_rd_addr;
    t_entry            w_rd_data;
    t_eval             w_eval;

    ckpr_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // The one shared unit: it judges the slot just read against the pending transaction.
    ckpr_eval u_eval (
        .i_op    (r_op),
        .i_page  (r_page),
        .i_entry (w_rd_data),
        .o_eval  (w_eval)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);

    // Effective capacity is the smaller of the register and the slot count.
    assign w_filled_ext = CW'(r_filled);
    assign w_eff_cap    = (CW'(r_capacity) < CW'(SLOTS)) ? CW'(r_capacity) : CW'(SLOTS);

    // Newest filled slot; the hand wraps to it from slot zero.
    assign w_last       = IDX_W'(r_filled - FILL_W'(1));
    assign w_slot       = (FILL_W'(r_hand) < r_filled) ? r_hand : w_last;
    assign w_step_limit = {r_filled, 1'b0};

    // The result register is free when empty or when its transaction goes out now.
    assign w_out_free   = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_page      = r_page;
        n_filled    = r_filled;
        n_hand      = r_hand;
        n_addr      = r_addr;
        n_steps     = r_steps;
        n_capacity  = r_capacity;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_addr;
        w_wr_data   = w_eval.entry;
        w_rd_en     = 1'b0;
        w_rd_addr   = r_addr;

        if (i_cfg_wr_en) begin
            n_capacity = i_cfg_wr_data;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op    = t_op'(i_in_item.operation);
                    n_page  = i_in_item.page;
                    n_steps = '0;
                    n_res   = '{status: ST_OK, victim_page: '0, victim_frame: '0};
                    n_state = S_DONE;
                    case (t_op'(i_in_item.operation))
                        OP_INSERT: begin
                            if (w_filled_ext >= w_eff_cap) begin
                                n_res.status = ST_FULL;
                            end else begin
                                // A fresh slot starts unreferenced and unpinned.
                                w_wr_en   = 1'b1;
                                w_wr_addr = IDX_W'(r_filled);
                                w_wr_data = '{tag: i_in_item.page, frame: i_in_item.frame,
                                              ref_bit: 1'b0, pin: '0};
                                n_filled  = r_filled + FILL_W'(1);
                                if ((w_filled_ext + CW'(1)) == w_eff_cap) begin
                                    n_hand = IDX_W'(r_filled);
                                end
                            end
                        end
                        OP_REPLACE: begin
                            if (w_filled_ext < w_eff_cap) begin
                                n_res.status = ST_NOT_FULL;
                            end else begin
                                n_state = S_READ;
                            end
                        end
                        default: begin
                            // Pin and unpin scan downward so the highest matching slot wins.
                            if (r_filled == '0) begin
                                n_res.status = ST_NOT_RESIDENT;
                            end else begin
                                n_addr  = w_last;
                                n_state = S_READ;
                            end
                        end
                    endcase
                end
            end
            S_READ: begin
                if (r_op == OP_REPLACE) begin
                    if (r_steps >= w_step_limit) begin
                        n_res.status = ST_NO_VICTIM;
                        n_state      = S_DONE;
                    end else begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = w_slot;
                        n_addr    = w_slot;
                        n_hand    = (w_slot == '0) ? w_last : w_slot - IDX_W'(1);
                        n_steps   = r_steps + SW'(1);
                        n_state   = S_CHECK;
                    end
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_addr;
                    n_state   = S_CHECK;
                end
            end
            S_CHECK: begin
                w_wr_en   = w_eval.do_write;
                w_wr_addr = r_addr;
                w_wr_data = w_eval.entry;
                if (r_op == OP_REPLACE) begin
                    if (w_eval.victim) begin
                        n_res   = '{status: ST_OK, victim_page: w_rd_data.tag,
                                    victim_frame: w_rd_data.frame};
                        n_state = S_DONE;
                    end else begin
                        n_state = S_READ;
                    end
                end else if (w_eval.match) begin
                    n_res.status = w_eval.status;
                    n_state      = S_DONE;
                end else if (r_addr == '0) begin
                    n_res.status = ST_NOT_RESIDENT;
                    n_state      = S_DONE;
                end else begin
                    n_addr  = r_addr - IDX_W'(1);
                    n_state = S_READ;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_filled    <= '0;
            r_hand      <= '0;
            r_steps     <= '0;
            r_capacity  <= CAPACITY_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_filled    <= n_filled;
            r_hand      <= n_hand;
            r_steps     <= n_steps;
            r_capacity  <= n_capacity;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload of the pending transaction and of the result.
    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_page <= n_page;
        r_addr <= n_addr;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

FILE: design/ckpr_checker.sv
// Port-level assertion checker for the clock page replacer, with its bind.
`include "assert_macros.svh"

module ckpr_checker
    import ckpr_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    `ASSERT_CLK(a_out_valid_held, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid, "result dropped under stall")
    `ASSERT_HOLD(a_out_item_held, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_item, "result changed under stall")
    `ASSERT_CLK(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall |=> o_in_stall, "input taken again before the transaction finished")
    `ASSERT_CLK(a_no_victim_on_error, i_clk, i_rst_n, o_out_valid && (o_out_item.status != ST_OK) |-> (o_out_item.victim_page == '0) && (o_out_item.victim_frame == '0), "error result carries a victim")

endmodule

bind clock_page_replacer ckpr_checker u_ckpr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

FILE: test/testbench.sv
// Self-checking testbench for the clock page replacer: directed rows, then random phases.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ckpr_pkg::*;

    // The pool size of the instance and of the local copy of the pool kept here.
    localparam int unsigned POOL_SLOTS = 64;

    // Each random phase starts with one capacity write. The list starts small, drops below
    // the fill level, touches both ends of the 7-bit field and ends above the pool size.
    localparam int unsigned PHASE_COUNT = 10;
    localparam logic [6:0] PHASE_CAPS [PHASE_COUNT] = '{
        7'd6, 7'd12, 7'd1, 7'd24, 7'd0, 7'd40, 7'd64, 7'd127, 7'd2, 7'd90
    };
    localparam int unsigned ITEMS_PER_PHASE = 115;

    // The page inserted last in the directed part, once the capacity is raised again.
    localparam logic [31:0] NEWEST_PAGE = 32'h0000_CAFE;

    // Length of the single long receiver hold-off, so that the block backs up.
    localparam int unsigned HOLD_OFF_CYCLES = 400;

    // One row of the directed part. A row either writes the capacity register or sends
    // one transaction. Where the result can be read off at a glance it is typed in the
    // row; every other row is checked against the local prediction.
    typedef struct packed {
        logic        is_cap;
        logic [6:0]  cap;
        t_op         op;
        logic [31:0] page;
        logic [5:0]  frame;
        logic        typed;
        t_status     status;
        logic [31:0] victim_page;
        logic [5:0]  victim_frame;
    } t_step_row;

    localparam int unsigned ROW_COUNT = 33;
    localparam t_step_row DIRECTED [ROW_COUNT] = '{
        // Straight out of reset the capacity is 64 and the pool is empty.
        '{1'b0, 7'd0,   OP_REPLACE, 32'h0000_0000, 6'd0,  1'b1, ST_NOT_FULL,     '0, '0},
        '{1'b0, 7'd0,   OP_PIN,     32'hFFFF_FFFF, 6'd0,  1'b1, ST_NOT_RESIDENT, '0, '0},
        '{1'b0, 7'd0,   OP_UNPIN,   32'h0000_0000, 6'd0,  1'b1, ST_NOT_RESIDENT, '0, '0},
        // Three frames: fill them, the first two with the extreme page and frame values.
        '{1'b1, 7'd3,   OP_INSERT,  32'h0000_0000, 6'd0,  1'b0, ST_OK,           '0, '0},
        '{1'b0, 7'd0,   OP_INSERT,  32'h0000_0000, 6'd0,  1'b1, ST_OK,           '0, '0},
        '{1'b0, 7'd0,   OP_INSERT,  32'hFFFF_FFFF, 6'd63, 1'b1, ST_OK,           '0, '0},
        '{1'b0, 7'd0,   OP_REPLACE, 32'h0000_0001, 6'd0,  1'b1, ST_NOT_FULL,     '0, '0},
        '{1'b0, 7'd0,   OP_INSERT,  32'h1234_5678, 6'd21, 1'b1, ST_OK,           '0, '0},
        '{1'b0, 7'd0,   OP_INSERT,  32'h0000_0007, 6'd5,  1'b1, ST_FULL,         '0, '0},
        '{1'b0, 7'd0,   OP_UNPIN,   32'h0000_0000, 6'd0,  1'b1, ST_UNPIN_ZERO,   '0, '0},
        // The hand sweeps past a pinned slot and clears reference bits on the way.
        '{1'b0, 7'd0,   OP_PIN,     32'hFFFF_FFFF, 6'd0,  1'b0, ST_OK,           '0, '0},
        '{1'b0, 7'd0,   OP_REPLACE, 32'hAAAA_5555, 6'd0,  1'b0, ST_OK,           '0, '0},
        '{1'b0, 7'd0,   OP_REPLACE, 32'h0000_0055, 6'd0,  1'b0, ST_OK,           '0, '0},
        '{1'b0, 7'd0,   OP_REPLACE, 32'h0000_0003, 6'd0,  1'b0, ST_OK,           '0, '0},
        '{1'b0, 7'd0,   OP_PIN,     32'h0000_0055, 6'd0,  1'b0, ST_OK,           '0, '0},
        '{1'b0, 7'd0,   OP_PIN,     32'h0000_0003, 6'd0,  1'b0, ST_OK,           '0, '0},
        // Every slot is pinned now, so the walk finds nothing.
        '{1'b0, 7'd0,   OP_REPLACE, 32'h0000_0009, 6'd0,  1'b1, ST_NO_VICTIM,    '0, '0},
        '{1'b0, 7'd0,   OP_UNPIN,   32'hFFFF_FFFF, 6'd0,  1'b0, ST_OK,           '0, '0},
        // Bringing in a page that is already resident leaves two slots with one tag;
        // pin and unpin must act on the higher-numbered one.
        '{1'b0, 7'd0,   OP_REPLACE, 32'h0000_0003, 6'd0,  1'b0, ST_OK,           '0, '0},
        '{1'b0, 7'd0,   OP_PIN,     32'h0000_0003, 6'd0,  1'b0, ST_OK,           '0, '0},
        '{1'b0, 7'd0,   OP_UNPIN,   32'h0000_0003, 6'd0,  1'b0, ST_OK,           '0, '0},
        '{1'b0, 7'd0,   OP_UNPIN,   32'h0000_0003, 6'd0,  1'b0, ST_OK,           '0, '0},
        '{1'b0, 7'd0,   OP_UNPIN,   32'h0000_0003, 6'd0,  1'b1, ST_UNPIN_ZERO,   '0, '0},
        // A capacity below the fill level makes the pool count as full.
        '{1'b1, 7'd1,   OP_INSERT,  32'h0000_0000, 6'd0,  1'b0, ST_OK,           '0, '0},
        '{1'b0, 7'd0,   OP_INSERT,  32'h0000_DEAD, 6'd1,  1'b1, ST_FULL,         '0, '0},
        '{1'b0, 7'd0,   OP_REPLACE, 32'h0000_0F0F, 6'd0,  1'b0, ST_OK,           '0, '0},
        '{1'b1, 7'd0,   OP_INSERT,  32'h0000_0000, 6'd0,  1'b0, ST_OK,           '0, '0},
        '{1'b0, 7'd0,   OP_REPLACE, 32'hF0F0_F0F0, 6'd0,  1'b0, ST_OK,           '0, '0},
        '{1'b0, 7'd0,   OP_INSERT,  32'h0000_0BAD, 6'd2,  1'b1, ST_FULL,         '0, '0},
        // The largest capacity is clipped to the pool size, so inserts resume.
        '{1'b1, 7'd127, OP_INSERT,  32'h0000_0000, 6'd0,  1'b0, ST_OK,           '0, '0},
        '{1'b0, 7'd0,   OP_INSERT,  NEWEST_PAGE,   6'd42, 1'b1, ST_OK,           '0, '0},
        '{1'b0, 7'd0,   OP_PIN,     32'h0000_1111, 6'd0,  1'b1, ST_NOT_RESIDENT, '0, '0},
        '{1'b0, 7'd0,   OP_UNPIN,   NEWEST_PAGE,   6'd0,  1'b1, ST_UNPIN_ZERO,   '0, '0}
    };

    logic      i_clk;
    logic      i_rst_n;
    logic      i_cfg_wr_en;
    logic [6:0] i_cfg_wr_data;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_item;

    clock_page_replacer #(
        .SLOTS(POOL_SLOTS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_item   (o_out_item)
    );

    // Local copy of the buffer pool, advanced once per accepted transaction.
    logic [31:0] pool_tag   [POOL_SLOTS];
    logic [5:0]  pool_frame [POOL_SLOTS];
    logic        pool_ref   [POOL_SLOTS];
    int unsigned pool_pin   [POOL_SLOTS];
    int unsigned pool_filled;
    int unsigned pool_hand;
    int unsigned pool_capacity;

    // Results still owed by the block, oldest first.
    t_out_item   awaited_results[$];
    int unsigned mismatches;

    // When set, neither side idles. Used for one whole random phase.
    logic        steady;
    // The sender asks for a hold-off by bumping this count; the receiver serves it.
    int unsigned hold_off_asked;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Works out the result of one transaction and advances the local pool. The hand
    // walks toward earlier-inserted slots and wraps from slot 0 to the newest one.
    function automatic t_out_item predict_replacer_result(input t_in_item request);
        t_out_item   verdict;
        int unsigned limit;
        int unsigned span;
        int unsigned slot;
        int          found;
        logic        got;
        verdict = '0;
        verdict.status = ST_OK;
        limit = (pool_capacity < POOL_SLOTS) ? pool_capacity : POOL_SLOTS;
        case (t_op'(request.operation))
            OP_INSERT: begin
                if (pool_filled >= limit) begin
                    verdict.status = ST_FULL;
                end else begin
                    slot = pool_filled;
                    pool_tag[slot] = request.page;
                    pool_frame[slot] = request.frame;
                    pool_ref[slot] = 1'b0;
                    pool_pin[slot] = 0;
                    pool_filled = slot + 1;
                    // Filling the last frame parks the hand on the newest slot.
                    if (pool_filled == limit) begin
                        pool_hand = slot;
                    end
                end
            end
            OP_REPLACE: begin
                if (pool_filled < limit) begin
                    verdict.status = ST_NOT_FULL;
                end else begin
                    span = pool_filled;
                    got = 1'b0;
                    // Two full turns are enough: the first clears reference bits.
                    for (int unsigned probe = 0; probe < 2 * span && !got; probe++) begin
                        slot = (pool_hand < span) ? pool_hand : span - 1;
                        pool_hand = (slot == 0) ? span - 1 : slot - 1;
                        if (pool_pin[slot] == 0) begin
                            if (pool_ref[slot]) begin
                                pool_ref[slot] = 1'b0;
                            end else begin
                                verdict.victim_page = pool_tag[slot];
                                verdict.victim_frame = pool_frame[slot];
                                pool_tag[slot] = request.page;
                                pool_ref[slot] = 1'b1;
                                got = 1'b1;
                            end
                        end
                    end
                    if (!got) begin
                        verdict.status = ST_NO_VICTIM;
                    end
                end
            end
            default: begin
                // Pin and unpin: the highest-numbered slot with the tag wins.
                found = -1;
                for (int unsigned i = 0; i < pool_filled; i++) begin
                    if (pool_tag[i] == request.page) begin
                        found = i;
                    end
                end
                if (found < 0) begin
                    verdict.status = ST_NOT_RESIDENT;
                end else if (t_op'(request.operation) == OP_PIN) begin
                    if (pool_pin[found] < PIN_MAX) begin
                        pool_pin[found]++;
                    end
                end else if (pool_pin[found] == 0) begin
                    verdict.status = ST_UNPIN_ZERO;
                end else begin
                    pool_pin[found]--;
                end
            end
        endcase
        return verdict;
    endfunction

    // Draws one random request. While the pool is still filling, inserts dominate; once
    // it is full, replaces, pins and unpins do. Pins and unpins mostly go to resident pages
    // so that lookups hit and the pin counts move in both directions.
    function automatic t_in_item draw_request();
        t_in_item    request;
        int unsigned limit;
        int unsigned roll;
        logic        resident;
        limit = (pool_capacity < POOL_SLOTS) ? pool_capacity : POOL_SLOTS;
        roll = $urandom_range(99);
        if (pool_filled < limit) begin
            request.operation = (roll < 70) ? OP_INSERT :
                                (roll < 80) ? OP_REPLACE :
                                (roll < 90) ? OP_PIN : OP_UNPIN;
        end else begin
            request.operation = (roll < 5)  ? OP_INSERT :
                                (roll < 50) ? OP_REPLACE :
                                (roll < 75) ? OP_PIN : OP_UNPIN;
        end
        if (request.operation == OP_PIN || request.operation == OP_UNPIN) begin
            resident = ($urandom_range(99) < 80);
        end else begin
            resident = ($urandom_range(99) < 15);
        end
        if (resident && pool_filled != 0) begin
            request.page = pool_tag[$urandom_range(pool_filled - 1)];
        end else begin
            request.page = $urandom();
        end
        request.frame = 6'($urandom_range(63));
        return request;
    endfunction

    // Offers one transaction, starting at a falling edge, and returns at the falling edge
    // after it was taken. Valid is left high so that a following transaction can go out
    // back to back; whoever stops sending lowers it.
    task automatic send_transaction(input t_in_item request, input logic typed,
                                    input t_out_item typed_result);
        t_out_item predicted;
        while (!steady && $urandom_range(99) < 16) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_item = request;
        do @(posedge i_clk); while (o_in_stall);
        predicted = predict_replacer_result(request);
        if (typed) begin
            predicted = typed_result;
        end
        awaited_results = {awaited_results, predicted};
        @(negedge i_clk);
    endtask

    // Stops sending and waits until the block has delivered everything it owes.
    task automatic drain_results();
        i_in_valid = 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // The register is only written while the block is idle. Every transaction yields
    // exactly one result, so an empty queue means the block has nothing in flight.
    task automatic write_capacity(input logic [6:0] value);
        drain_results();
        repeat (2) @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_wr_data = value;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        pool_capacity = 32'(value);
    endtask

    task automatic flag_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch in %s: expected %0h, got %0h", field, want, got);
        end
    endtask

    // Receiver: idles at random, holds off once for a long stretch on request, and
    // stays quiet during steady stretches.
    initial begin
        int unsigned hold_off_served;
        int unsigned hold_off_left;
        hold_off_served = 0;
        hold_off_left = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_served != hold_off_asked) begin
                hold_off_served = hold_off_asked;
                hold_off_left = HOLD_OFF_CYCLES;
            end
            if (hold_off_left != 0) begin
                i_out_stall = 1'b1;
                hold_off_left--;
            end else if (steady) begin
                i_out_stall = 1'b0;
            end else begin
                i_out_stall = ($urandom_range(99) < 16);
            end
        end
    end

    // Result checker: every accepted result is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item wanted;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result %0h arrived with nothing outstanding", o_out_item);
                end
            end else begin
                wanted = awaited_results.pop_front();
                if (o_out_item.status !== wanted.status) begin
                    flag_field("status", 32'(wanted.status), 32'(o_out_item.status));
                end
                if (o_out_item.victim_page !== wanted.victim_page) begin
                    flag_field("victim_page", wanted.victim_page, o_out_item.victim_page);
                end
                if (o_out_item.victim_frame !== wanted.victim_frame) begin
                    flag_field("victim_frame", 32'(wanted.victim_frame),
                               32'(o_out_item.victim_frame));
                end
            end
        end
    end

    // Stimulus sequence: reset, the directed rows, the random phases, and the final drain.
    initial begin
        t_in_item  request;
        t_out_item typed_result;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        steady = 1'b0;
        hold_off_asked = 0;
        mismatches = 0;
        pool_filled = 0;
        pool_hand = 0;
        pool_capacity = 32'(CAPACITY_RESET);
        for (int unsigned i = 0; i < POOL_SLOTS; i++) begin
            pool_tag[i] = '0;
            pool_frame[i] = '0;
            pool_ref[i] = 1'b0;
            pool_pin[i] = 0;
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int unsigned r = 0; r < ROW_COUNT; r++) begin
            if (DIRECTED[r].is_cap) begin
                write_capacity(DIRECTED[r].cap);
            end else begin
                request.operation = DIRECTED[r].op;
                request.page = DIRECTED[r].page;
                request.frame = DIRECTED[r].frame;
                typed_result.status = DIRECTED[r].status;
                typed_result.victim_page = DIRECTED[r].victim_page;
                typed_result.victim_frame = DIRECTED[r].victim_frame;
                send_transaction(request, DIRECTED[r].typed, typed_result);
            end
        end

        for (int unsigned p = 0; p < PHASE_COUNT; p++) begin
            write_capacity(PHASE_CAPS[p]);
            // One whole phase runs without any idling on either side.
            steady = (p == 3);
            for (int unsigned k = 0; k < ITEMS_PER_PHASE; k++) begin
                // The receiver stops for a long stretch while requests keep coming,
                // so the block fills up and stalls its input.
                if (p == 1 && k == 40) begin
                    hold_off_asked++;
                end
                // Once in mid-phase the sender waits for every result before going on.
                if (p == 5 && k == 60) begin
                    drain_results();
                end
                send_transaction(draw_request(), 1'b0, '0);
            end
        end
        steady = 1'b0;

        drain_results();
        // A final wait after the drain, sized for the longest replace over a full pool.
        repeat (4 * POOL_SLOTS + 40) @(posedge i_clk);
        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    // Watchdog: the slowest correct run stays far below this.
    initial begin
        #50_000_000;
        $display("testbench: errors");
        $finish;
    end

endmodule
